>>> hw/rtl/rlebd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlebd_pkg
// Shared types and codes for the run-length region bitmap decoder: result
// kinds, header opcodes and the per-byte result group.
// ----------------------------------------------------------------------------
package rlebd_pkg;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 10;
    localparam int CNT_W   = 14;
    localparam int SUM_W   = 15;

    localparam logic [KIND_W-1:0] KIND_RUN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] OP_SKIP_CELLS = 2'd0;
    localparam logic [1:0] OP_SET_RUN    = 2'd1;
    localparam logic [1:0] OP_SKIP_ROWS  = 2'd2;
    localparam logic [1:0] OP_REPEAT_ROW = 2'd3;

    // All results caused by one input byte: an optional command, then an
    // optional end-of-chunk status.
    typedef struct packed {
        logic               has_cmd;
        logic [KIND_W-1:0]  cmd_kind;
        logic [COORD_W-1:0] cmd_col;
        logic [COORD_W-1:0] cmd_row;
        logic [CNT_W-1:0]   cmd_count;
        logic               has_status;
        logic               status;
    } grp_t;

endpackage

>>> hw/rtl/rle_region_bitmap_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_region_bitmap_decoder
// Decodes a run-length coded membership bitmap one byte per request into
// set-cell run and repeat-row commands, plus a status on the last byte.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register and decoded from
//   there; its results enter the result queue, which presents them.
// Throughput: one byte per cycle while the result queue has room; a byte
//   with a command and a status gives two results; the queue is two deep.
// Reset: synchronous, active low; clears the decode state, the input valid
//   flag and the result queue.
module rle_region_bitmap_decoder #(
    parameter int MAP_DIM = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_end_of_chunk,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rlebd_pkg::KIND_W-1:0]     m_kind,
    output logic [rlebd_pkg::COORD_W-1:0]    m_start_col,
    output logic [rlebd_pkg::COORD_W-1:0]    m_start_row,
    output logic [rlebd_pkg::CNT_W-1:0]      m_run_count,
    output logic                             m_status,
    output logic                             m_last
);

    localparam int COL_W = $clog2(MAP_DIM + 1);
    localparam int ROW_W = $clog2(MAP_DIM + 1);
    localparam logic [rlebd_pkg::SUM_W-1:0] DIM_SUM = rlebd_pkg::SUM_W'(MAP_DIM);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_eoc_reg;

    // decode state
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic             await_second_reg, await_second_next;
    logic [7:0]       held_header_reg, held_header_next;
    logic             bad_stream_reg, bad_stream_next;

    // result queue
    rlebd_pkg::grp_t grp_reg [2];
    logic [1:0]      grp_cnt_reg;
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic            phase_reg;

    rlebd_pkg::grp_t grp_new;
    rlebd_pkg::grp_t head;
    logic            fire;
    logic            push;
    logic            pop;
    logic            out_fire;
    logic            room;

    // decode datapath
    logic [7:0]                     hdr;
    logic [1:0]                     op;
    logic [rlebd_pkg::CNT_W-1:0]    count;
    logic [rlebd_pkg::SUM_W-1:0]    col_sum;
    logic [rlebd_pkg::SUM_W-1:0]    row_sum;
    logic                           exec;
    logic                           in_range;

    assign head     = grp_reg[rd_ptr_reg];
    assign m_valid  = (grp_cnt_reg != 2'd0);
    assign out_fire = m_valid && m_ready;
    assign pop      = out_fire && (phase_reg || !head.has_cmd || !head.has_status);
    assign room     = (grp_cnt_reg != 2'd2) || pop;
    assign fire     = in_valid_reg && room;
    assign s_ready  = !in_valid_reg || fire;

    always_comb begin
        if (head.has_cmd && !phase_reg) begin
            m_kind      = head.cmd_kind;
            m_start_col = head.cmd_col;
            m_start_row = head.cmd_row;
            m_run_count = head.cmd_count;
            m_status    = 1'b0;
            m_last      = !head.has_status;
        end else begin
            m_kind      = rlebd_pkg::KIND_STATUS;
            m_start_col = '0;
            m_start_row = '0;
            m_run_count = '0;
            m_status    = head.status;
            m_last      = 1'b1;
        end
    end

    always_comb begin
        hdr      = await_second_reg ? held_header_reg : in_data_reg;
        op       = hdr[7:6];
        count    = await_second_reg
                 ? rlebd_pkg::CNT_W'({hdr[4:0], in_data_reg}) + rlebd_pkg::CNT_W'(1)
                 : rlebd_pkg::CNT_W'(in_data_reg[4:0]) + rlebd_pkg::CNT_W'(1);
        col_sum  = rlebd_pkg::SUM_W'(cur_col_reg) + rlebd_pkg::SUM_W'(count);
        row_sum  = rlebd_pkg::SUM_W'(cur_row_reg) + rlebd_pkg::SUM_W'(count);
        in_range = (rlebd_pkg::SUM_W'(cur_col_reg) < DIM_SUM)
                && (rlebd_pkg::SUM_W'(cur_row_reg) < DIM_SUM);
        exec     = !bad_stream_reg && (await_second_reg || (in_range && !in_data_reg[5]));

        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        await_second_next = 1'b0;
        held_header_next  = held_header_reg;
        bad_stream_next   = bad_stream_reg;

        grp_new            = '0;
        grp_new.cmd_kind   = rlebd_pkg::KIND_RUN;
        grp_new.cmd_count  = count;

        if (!bad_stream_reg && !await_second_reg) begin
            if (!in_range) begin
                bad_stream_next = 1'b1;
            end else if (in_data_reg[5]) begin
                if (in_eoc_reg) begin
                    bad_stream_next = 1'b1;
                end else begin
                    await_second_next = 1'b1;
                    held_header_next  = in_data_reg;
                end
            end
        end

        if (exec) begin
            unique case (op)
                rlebd_pkg::OP_SKIP_CELLS, rlebd_pkg::OP_SET_RUN: begin
                    if (col_sum > DIM_SUM) begin
                        bad_stream_next = 1'b1;
                    end else begin
                        if (op == rlebd_pkg::OP_SET_RUN) begin
                            grp_new.has_cmd  = 1'b1;
                            grp_new.cmd_kind = rlebd_pkg::KIND_RUN;
                            grp_new.cmd_col  = rlebd_pkg::COORD_W'(cur_col_reg);
                            grp_new.cmd_row  = rlebd_pkg::COORD_W'(cur_row_reg);
                        end
                        if (col_sum == DIM_SUM) begin
                            cur_col_next = '0;
                            cur_row_next = cur_row_reg + ROW_W'(1);
                        end else begin
                            cur_col_next = COL_W'(col_sum);
                        end
                    end
                end
                rlebd_pkg::OP_SKIP_ROWS: begin
                    if (cur_col_reg != '0 || row_sum > DIM_SUM) begin
                        bad_stream_next = 1'b1;
                    end else begin
                        cur_row_next = ROW_W'(row_sum);
                    end
                end
                rlebd_pkg::OP_REPEAT_ROW: begin
                    if (cur_col_reg != '0 || cur_row_reg == '0 || row_sum > DIM_SUM) begin
                        bad_stream_next = 1'b1;
                    end else begin
                        grp_new.has_cmd  = 1'b1;
                        grp_new.cmd_kind = rlebd_pkg::KIND_REPEAT;
                        grp_new.cmd_row  = rlebd_pkg::COORD_W'(cur_row_reg);
                        cur_row_next     = ROW_W'(row_sum);
                    end
                end
                default: begin
                    bad_stream_next = 1'b1;
                end
            endcase
        end

        if (in_eoc_reg) begin
            grp_new.has_status = 1'b1;
            grp_new.status     = bad_stream_next
                              || (rlebd_pkg::SUM_W'(cur_row_next) != DIM_SUM);
            cur_col_next       = '0;
            cur_row_next       = '0;
            await_second_next  = 1'b0;
            held_header_next   = '0;
            bad_stream_next    = 1'b0;
        end

        push = fire && (grp_new.has_cmd || grp_new.has_status);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            await_second_reg <= 1'b0;
            held_header_reg  <= '0;
            bad_stream_reg   <= 1'b0;
            grp_cnt_reg      <= '0;
            wr_ptr_reg       <= 1'b0;
            rd_ptr_reg       <= 1'b0;
            phase_reg        <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                cur_col_reg      <= cur_col_next;
                cur_row_reg      <= cur_row_next;
                await_second_reg <= await_second_next;
                held_header_reg  <= held_header_next;
                bad_stream_reg   <= bad_stream_next;
            end
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            grp_cnt_reg <= grp_cnt_reg + 2'(push) - 2'(pop);
            if (out_fire) begin
                phase_reg <= !pop;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_eoc_reg  <= s_end_of_chunk;
        end
        if (push) begin
            grp_reg[wr_ptr_reg] <= grp_new;
        end
    end

endmodule

>>> hw/rtl/rlebd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlebd_checker
// Port-level checks on the result channel of the region bitmap decoder.
// ----------------------------------------------------------------------------
module rlebd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rlebd_pkg::KIND_W-1:0]  m_kind,
    input logic [rlebd_pkg::COORD_W-1:0] m_start_col,
    input logic [rlebd_pkg::COORD_W-1:0] m_start_row,
    input logic [rlebd_pkg::CNT_W-1:0]   m_run_count,
    input logic                          m_status,
    input logic                          m_last
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_start_col)
            && $stable(m_start_row) && $stable(m_run_count) && $stable(m_status)
            && $stable(m_last))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == rlebd_pkg::KIND_STATUS |-> m_last && m_start_col == '0
            && m_start_row == '0 && m_run_count == '0)
        else $error("status request malformed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != rlebd_pkg::KIND_STATUS |-> !m_status && m_run_count != '0)
        else $error("command request malformed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == rlebd_pkg::KIND_REPEAT |-> m_start_col == '0
            && m_start_row != '0)
        else $error("repeat at row zero or nonzero column");

endmodule

bind rle_region_bitmap_decoder rlebd_checker u_rlebd_checker (.*);
